FILE: src/uhpt_pkg.sv
package uhpt_pkg;

    localparam int KEY_W          = 31;
    localparam int NUM_COEFS      = 8;
    localparam int COEF_BITS      = 5;
    localparam int COEF_W         = NUM_COEFS * COEF_BITS;
    localparam int DIG_W          = $clog2(NUM_COEFS);
    localparam int SLOT_W         = 5;
    localparam int PROBE_W        = 5;
    localparam int STATUS_W       = 3;
    localparam int DEF_TABLE_SIZE = 17;

    // digit < 32 and coefficient < 32, at most eight terms
    localparam int ACC_W          = 2 * COEF_BITS + DIG_W;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_STORED    = 3'd0;
    localparam status_t ST_FOUND     = 3'd1;
    localparam status_t ST_NOT_FOUND = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_ZERO_KEY  = 3'd4;

endpackage

FILE: src/universal_hash_probing_table_top.sv
// Channel  Ports                                  Transfer
// input    start, busy, kind, key                 start high and busy low at a clock edge
// result   done, status, slot, probes             done high for one cycle, always taken
// config   cfg_we, cfg_data                       cfg_we high at a clock edge, no wait
//
// Zero key: result in the cycle after the transaction, block stays free.
// Other keys: busy while the digit loop, the final accumulate, the modulo reduction and the
// probe loop run; the probe loop steps past 0..TABLE_SIZE-1 slots before the last one read.
// The digit loop shares one constant divider; the probe loop reads one slot per cycle.
// Reset clears the table at once through per-slot valid bits; coefficients reset to 0.
// The receiver cannot stall; a result never holds off the next transaction.
module universal_hash_probing_table_top #(
    parameter int TABLE_SIZE = uhpt_pkg::DEF_TABLE_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              kind,
    input  logic [uhpt_pkg::KEY_W-1:0]        key,
    input  logic                              cfg_we,
    input  logic [uhpt_pkg::COEF_W-1:0]       cfg_data,
    output logic                              done,
    output logic [uhpt_pkg::STATUS_W-1:0]     status,
    output logic [uhpt_pkg::SLOT_W-1:0]       slot,
    output logic [uhpt_pkg::PROBE_W-1:0]      probes
);

    localparam int IDXW = $clog2(TABLE_SIZE);
    localparam int NDIG = (TABLE_SIZE < uhpt_pkg::NUM_COEFS) ? TABLE_SIZE
                                                             : uhpt_pkg::NUM_COEFS;
    localparam logic [uhpt_pkg::DIG_W-1:0] LAST_DIG = uhpt_pkg::DIG_W'(NDIG - 1);
    localparam logic [IDXW-1:0]            LAST_POS = IDXW'(TABLE_SIZE - 1);
    localparam logic [uhpt_pkg::PROBE_W-1:0] ALL_PROBES = uhpt_pkg::PROBE_W'(TABLE_SIZE);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIVA  = 8'b0000_0010,
        S_DIVB  = 8'b0000_0100,
        S_ACC   = 8'b0000_1000,
        S_MODA  = 8'b0001_0000,
        S_MODB  = 8'b0010_0000,
        S_RD    = 8'b0100_0000,
        S_PROBE = 8'b1000_0000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [uhpt_pkg::COEF_W-1:0]      coef_reg;
    logic                             kind_reg;
    logic                             kind_next;
    logic [uhpt_pkg::KEY_W-1:0]       key_reg;
    logic [uhpt_pkg::KEY_W-1:0]       key_next;
    logic [uhpt_pkg::DIG_W-1:0]       dig_reg;
    logic [uhpt_pkg::DIG_W-1:0]       dig_next;
    logic [uhpt_pkg::ACC_W-1:0]       acc_reg;
    logic [uhpt_pkg::ACC_W-1:0]       acc_next;
    logic [IDXW-1:0]                  home_reg;
    logic [IDXW-1:0]                  home_next;
    logic [IDXW-1:0]                  pos_reg;
    logic [IDXW-1:0]                  pos_next;
    logic [IDXW-1:0]                  cnt_reg;
    logic [IDXW-1:0]                  cnt_next;
    logic                             done_reg;
    logic                             done_next;
    uhpt_pkg::status_t                status_reg;
    uhpt_pkg::status_t                status_next;
    logic [uhpt_pkg::SLOT_W-1:0]      slot_reg;
    logic [uhpt_pkg::SLOT_W-1:0]      slot_next;
    logic [uhpt_pkg::PROBE_W-1:0]     probes_reg;
    logic [uhpt_pkg::PROBE_W-1:0]     probes_next;

    logic [uhpt_pkg::KEY_W-1:0]       mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]            valid_reg;
    logic [uhpt_pkg::KEY_W-1:0]       rd_data_reg;
    logic                             rd_valid_reg;
    logic [IDXW-1:0]                  rd_addr;
    logic                             mem_we;
    logic [uhpt_pkg::KEY_W-1:0]       entry;
    logic [IDXW-1:0]                  pos_inc;

    logic [uhpt_pkg::KEY_W-1:0]       div_n;
    logic [uhpt_pkg::KEY_W-1:0]       div_q;
    logic [uhpt_pkg::SLOT_W-1:0]      div_r;
    logic [uhpt_pkg::DIG_W-1:0]       coef_idx;
    logic [uhpt_pkg::COEF_BITS-1:0]   coef_sel;
    logic [2*uhpt_pkg::COEF_BITS-1:0] mac_prod;
    logic [uhpt_pkg::ACC_W-1:0]       mac_sum;

    uhpt_cdiv #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_cdiv (
        .clk  (clk),
        .n    (div_n),
        .quot (div_q),
        .rem  (div_r)
    );

    assign coef_sel = coef_reg[coef_idx*uhpt_pkg::COEF_BITS +: uhpt_pkg::COEF_BITS];
    assign mac_prod = (2*uhpt_pkg::COEF_BITS)'(div_r) * (2*uhpt_pkg::COEF_BITS)'(coef_sel);
    assign mac_sum  = acc_reg + uhpt_pkg::ACC_W'(mac_prod);
    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign entry    = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        key_next    = key_reg;
        dig_next    = dig_reg;
        acc_next    = acc_reg;
        home_next   = home_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        slot_next   = slot_reg;
        probes_next = probes_reg;
        mem_we      = 1'b0;
        div_n       = key_reg;
        coef_idx    = dig_reg - 1'b1;
        rd_addr     = pos_inc;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (key == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = uhpt_pkg::ST_ZERO_KEY;
                        slot_next   = '0;
                        probes_next = '0;
                    end
                    else
                    begin
                        kind_next  = kind;
                        key_next   = key;
                        dig_next   = '0;
                        acc_next   = '0;
                        state_next = S_DIVA;
                    end
                end
            end
            S_DIVA:
            begin
                div_n = (dig_reg == '0) ? key_reg : div_q;
                if (dig_reg != '0)
                begin
                    acc_next = mac_sum;
                end
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                if (dig_reg == LAST_DIG)
                begin
                    state_next = S_ACC;
                end
                else
                begin
                    dig_next   = dig_reg + 1'b1;
                    state_next = S_DIVA;
                end
            end
            S_ACC:
            begin
                coef_idx   = dig_reg;
                acc_next   = mac_sum;
                state_next = S_MODA;
            end
            S_MODA:
            begin
                div_n      = uhpt_pkg::KEY_W'(acc_reg);
                state_next = S_MODB;
            end
            S_MODB:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                home_next  = div_r[IDXW-1:0];
                pos_next   = div_r[IDXW-1:0];
                rd_addr    = div_r[IDXW-1:0];
                cnt_next   = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (!kind_reg && entry == '0)
                begin
                    mem_we      = 1'b1;
                    done_next   = 1'b1;
                    status_next = uhpt_pkg::ST_STORED;
                    slot_next   = uhpt_pkg::SLOT_W'(pos_reg);
                    probes_next = uhpt_pkg::PROBE_W'(cnt_reg);
                    state_next  = S_IDLE;
                end
                else if (kind_reg && entry == key_reg)
                begin
                    done_next   = 1'b1;
                    status_next = uhpt_pkg::ST_FOUND;
                    slot_next   = uhpt_pkg::SLOT_W'(pos_reg);
                    probes_next = uhpt_pkg::PROBE_W'(cnt_reg);
                    state_next  = S_IDLE;
                end
                else if (kind_reg && entry == '0)
                begin
                    done_next   = 1'b1;
                    status_next = uhpt_pkg::ST_NOT_FOUND;
                    slot_next   = uhpt_pkg::SLOT_W'(home_reg);
                    probes_next = uhpt_pkg::PROBE_W'(cnt_reg);
                    state_next  = S_IDLE;
                end
                else if (cnt_reg == LAST_POS)
                begin
                    done_next   = 1'b1;
                    status_next = kind_reg ? uhpt_pkg::ST_NOT_FOUND : uhpt_pkg::ST_FULL;
                    slot_next   = uhpt_pkg::SLOT_W'(home_reg);
                    probes_next = ALL_PROBES;
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next = pos_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            coef_reg  <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                coef_reg <= cfg_data;
            end
            if (mem_we)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        dig_reg      <= dig_next;
        acc_reg      <= acc_next;
        home_reg     <= home_next;
        pos_reg      <= pos_next;
        cnt_reg      <= cnt_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        probes_reg   <= probes_next;
        rd_valid_reg <= valid_reg[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg] <= key_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign slot   = slot_reg;
    assign probes = probes_reg;

    ast_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key == '0) |=> (done && status == uhpt_pkg::ST_ZERO_KEY))
        else $error("zero key transaction did not give an immediate reject");

    ast_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && key != '0) |=> (!done && busy))
        else $error("hashed transaction produced a result too early");

    ast_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_PROBE && !kind_reg))
        else $error("table write outside an insert probe");

    ast_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("probe finished without a result");

    ast_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (slot < uhpt_pkg::SLOT_W'(TABLE_SIZE)))
        else $error("result slot out of table range");

endmodule

FILE: src/uhpt_cdiv.sv
module uhpt_cdiv #(
    parameter int TABLE_SIZE = uhpt_pkg::DEF_TABLE_SIZE
) (
    input  logic                              clk,
    input  logic [uhpt_pkg::KEY_W-1:0]        n,
    output logic [uhpt_pkg::KEY_W-1:0]        quot,
    output logic [uhpt_pkg::SLOT_W-1:0]       rem
);

    // quotient by reciprocal multiply, exact for every KEY_W-bit operand
    localparam int SHIFT   = uhpt_pkg::KEY_W + $clog2(TABLE_SIZE);
    localparam int RECIP_W = uhpt_pkg::KEY_W + 2;
    localparam int PROD_W  = uhpt_pkg::KEY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) / TABLE_SIZE) + 1);
    localparam logic [uhpt_pkg::SLOT_W-1:0] DIVISOR = uhpt_pkg::SLOT_W'(TABLE_SIZE);

    logic [PROD_W-1:0]                prod_reg;
    logic [PROD_W-1:0]                prod_next;
    logic [uhpt_pkg::SLOT_W-1:0]      nlo_reg;
    logic [uhpt_pkg::KEY_W-1:0]       quot_reg;
    logic [uhpt_pkg::KEY_W-1:0]       quot_next;
    logic [uhpt_pkg::SLOT_W-1:0]      rem_reg;
    logic [uhpt_pkg::SLOT_W-1:0]      rem_next;
    logic [uhpt_pkg::SLOT_W-1:0]      qt_lo;

    assign prod_next = PROD_W'(n) * PROD_W'(RECIP);
    assign quot_next = uhpt_pkg::KEY_W'(prod_reg >> SHIFT);

    // remainder < 32, so the low bits of n - q*T are enough
    assign qt_lo     = quot_next[uhpt_pkg::SLOT_W-1:0] * DIVISOR;
    assign rem_next  = nlo_reg - qt_lo;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        nlo_reg  <= n[uhpt_pkg::SLOT_W-1:0];
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;

endmodule
